FILE: hdl/izp_pkg.sv
package izp_pkg;

  localparam int Z_W = 24;
  localparam int Q_W = 25;
  localparam int D_W = 34;

  localparam int MIDQ_DEPTH = 32;
  localparam int OUTQ_DEPTH = 8;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [1:0] KIND_IMAGE   = 2'd0;
  localparam logic [1:0] KIND_CHECKER = 2'd1;
  localparam logic [1:0] KIND_BLANK   = 2'd2;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_IMAGE_PRESENT = 3'd2;
  localparam logic [2:0] REG_ZOOM_FACTOR   = 3'd3;
  localparam logic [2:0] REG_PAN_OFFSET_X  = 3'd4;
  localparam logic [2:0] REG_PAN_OFFSET_Y  = 3'd5;
  localparam logic [2:0] REG_PANEL_WIDTH   = 3'd6;
  localparam logic [2:0] REG_PANEL_HEIGHT  = 3'd7;

  localparam logic [Z_W-1:0] ZOOM_MIN   = 24'd655;
  localparam logic [Z_W-1:0] ZOOM_UNITY = 24'd65536;

  localparam logic [7:0] GREY_DARK  = 8'd30;
  localparam logic [7:0] GREY_LIGHT = 8'd40;
  localparam logic [7:0] GREY_BACK  = 8'd25;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [8:0]     width;
    logic [8:0]     height;
    logic           present;
    logic [Z_W-1:0] zoom;
    logic [15:0]    pan_x;
    logic [15:0]    pan_y;
    logic [14:0]    panel_w;
    logic [14:0]    panel_h;
  } izp_cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  kind;
    logic        grey;
    logic [15:0] index;
    logic [31:0] value;
  } izp_meta_t;

  typedef struct packed {
    izp_meta_t      meta;
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qy;
  } izp_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] kind;
  } izp_result_t;

endpackage

FILE: hdl/izp_ram.sv
module izp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/izp_fifo.sv
module izp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_pop;

  assign do_pop = pop && (count != '0);
  assign empty  = (count == '0);
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/izp_div.sv
module izp_div (
  input  logic                     clk,
  input  logic [izp_pkg::D_W-1:0]  dividend,
  input  logic [izp_pkg::Z_W:0]    divisor,
  output logic [izp_pkg::Q_W-1:0]  quotient
);

  localparam int QW = izp_pkg::Q_W;
  localparam int DV = izp_pkg::Z_W + 1;
  localparam int RW = izp_pkg::D_W + 16;

  logic [RW-1:0] rem [QW+1];
  logic [DV-1:0] dsr [QW+1];
  logic [QW-1:0] quo [QW+1];

  // dividend is taken in Q.16
  always_ff @(posedge clk) begin
    rem[0] <= {dividend, 16'b0};
    dsr[0] <= divisor;
    quo[0] <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;
    logic [RW-1:0] sh;
    assign sh = {{(RW - DV){1'b0}}, dsr[g]} << B;

    always_ff @(posedge clk) begin
      dsr[g+1] <= dsr[g];
      if (rem[g] >= sh) begin
        rem[g+1] <= rem[g] - sh;
        quo[g+1] <= quo[g] | (QW'(1) << B);
      end else begin
        rem[g+1] <= rem[g];
        quo[g+1] <= quo[g];
      end
    end
  end

  assign quotient = quo[QW];

endmodule

FILE: hdl/izp_front.sv
module izp_front #(
  parameter int CHECKER_CELL = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  izp_pkg::izp_cfg_t   cfg,
  input  logic                in_valid,
  input  logic                cmd,
  input  logic [15:0]         pixel_index,
  input  logic [31:0]         pixel_value,
  input  logic [13:0]         panel_col,
  input  logic [13:0]         panel_row,
  output logic                out_valid,
  output izp_pkg::izp_item_t  out_item
);

  localparam int QW = izp_pkg::Q_W;

  function automatic logic signed [36:0] axis_d(input logic [13:0] pos,
                                                input logic [15:0] pan,
                                                input logic [14:0] panel,
                                                input logic [32:0] nz);
    logic signed [17:0] diff;
    diff = $signed({4'b0, pos}) - $signed({{2{pan[15]}}, pan});
    return ($signed({{19{diff[17]}}, diff}) <<< 17) - $signed({6'b0, panel, 16'b0})
           + $signed({4'b0, nz});
  endfunction

  // stage 1: capture the word
  logic        v1, cmd1, grey1;
  logic [15:0] idx1;
  logic [31:0] val1;
  logic [13:0] col1, row1;
  logic [13:0] cell_x, cell_y;

  assign cell_x = 14'(panel_col / CHECKER_CELL);
  assign cell_y = 14'(panel_row / CHECKER_CELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    cmd1  <= cmd;
    grey1 <= cell_x[0] ^ cell_y[0];
    idx1  <= pixel_index;
    val1  <= pixel_value;
    col1  <= panel_col;
    row1  <= panel_row;
  end

  // stage 2: doubled offset from the centred origin, in Q.16
  logic [32:0]        nzx, nzy;
  logic               v2, cmd2, grey2;
  logic [15:0]        idx2;
  logic [31:0]        val2;
  logic signed [36:0] dx2, dy2;
  logic [33:0]        limx2, limy2;

  assign nzx = 33'(cfg.width) * 33'(cfg.zoom);
  assign nzy = 33'(cfg.height) * 33'(cfg.zoom);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cmd2  <= cmd1;
    grey2 <= grey1;
    idx2  <= idx1;
    val2  <= val1;
    dx2   <= axis_d(col1, cfg.pan_x, cfg.panel_w, nzx);
    dy2   <= axis_d(row1, cfg.pan_y, cfg.panel_h, nzy);
    limx2 <= {nzx, 1'b0};
    limy2 <= {nzy, 1'b0};
  end

  // classify, then run both axes through the dividers
  logic              in_x, in_y;
  logic [1:0]        kind2;
  logic [QW:0]       vld;
  izp_pkg::izp_meta_t meta [QW+1];
  logic [QW-1:0]     qx, qy;

  assign in_x = !dx2[36] && (dx2[35:0] < {2'b0, limx2});
  assign in_y = !dy2[36] && (dy2[35:0] < {2'b0, limy2});

  always_comb begin
    if (!cfg.present) begin
      kind2 = izp_pkg::KIND_BLANK;
    end else if (!(in_x && in_y)) begin
      kind2 = izp_pkg::KIND_CHECKER;
    end else begin
      kind2 = izp_pkg::KIND_IMAGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-1:0], v2};
    end
    meta[0] <= '{cmd: cmd2, kind: kind2, grey: grey2, index: idx2, value: val2};
    for (int i = 0; i < QW; i++) begin
      meta[i+1] <= meta[i];
    end
  end

  izp_div u_div_x (
    .clk      (clk),
    .dividend (dx2[izp_pkg::D_W-1:0]),
    .divisor  ({cfg.zoom, 1'b0}),
    .quotient (qx)
  );

  izp_div u_div_y (
    .clk      (clk),
    .dividend (dy2[izp_pkg::D_W-1:0]),
    .divisor  ({cfg.zoom, 1'b0}),
    .quotient (qy)
  );

  assign out_valid = vld[QW];
  assign out_item  = '{meta: meta[QW], qx: qx, qy: qy};

endmodule

FILE: hdl/izp_back.sv
module izp_back #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  izp_pkg::izp_cfg_t    cfg,
  input  logic                 in_valid,
  input  izp_pkg::izp_item_t   in_item,
  output logic                 out_valid,
  output izp_pkg::izp_result_t out_res
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int QW = izp_pkg::Q_W;

  // stage 1: taps and weights; nearest mode is bilinear with zero fraction
  logic        bil;
  logic [8:0]  ix, iy, ix1, iy1;
  logic [16:0] fx, fy, gx, gy;

  assign bil = cfg.zoom < izp_pkg::ZOOM_UNITY;
  assign ix  = in_item.qx[QW-1:16];
  assign iy  = in_item.qy[QW-1:16];
  assign fx  = bil ? {1'b0, in_item.qx[15:0]} : 17'd0;
  assign fy  = bil ? {1'b0, in_item.qy[15:0]} : 17'd0;
  assign gx  = 17'h10000 - fx;
  assign gy  = 17'h10000 - fy;
  // replicate the last column and row
  assign ix1 = (bil && ({1'b0, ix} + 10'd1 < {1'b0, cfg.width})) ? ix + 9'd1 : ix;
  assign iy1 = (bil && ({1'b0, iy} + 10'd1 < {1'b0, cfg.height})) ? iy + 9'd1 : iy;

  logic               v1;
  izp_pkg::izp_meta_t m1;
  logic [8:0]         x0_1, x1_1;
  logic [17:0]        base0_1, base1_1;
  logic [32:0]        w1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    m1      <= in_item.meta;
    x0_1    <= ix;
    x1_1    <= ix1;
    base0_1 <= 18'(iy) * 18'(cfg.width);
    base1_1 <= 18'(iy1) * 18'(cfg.width);
    w1[0]   <= 33'(gx) * 33'(gy);
    w1[1]   <= 33'(fx) * 33'(gy);
    w1[2]   <= 33'(gx) * 33'(fy);
    w1[3]   <= 33'(fx) * 33'(fy);
  end

  // stage 2: addresses into four copies of the image
  logic [19:0]   lin [4];
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic          we;
  logic [31:0]   pix [4];

  assign lin[0] = {2'b0, base0_1} + {11'b0, x0_1};
  assign lin[1] = {2'b0, base0_1} + {11'b0, x1_1};
  assign lin[2] = {2'b0, base1_1} + {11'b0, x0_1};
  assign lin[3] = {2'b0, base1_1} + {11'b0, x1_1};
  assign we     = v1 && (m1.cmd == izp_pkg::CMD_LOAD);
  assign waddr  = AW'(m1.index % MAX_PIXELS);

  for (genvar t = 0; t < 4; t++) begin : g_bank
    assign raddr[t] = AW'(lin[t] % MAX_PIXELS);
    izp_ram #(.WIDTH(32), .DEPTH(MAX_PIXELS)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (m1.value),
      .raddr (raddr[t]),
      .rdata (pix[t])
    );
  end

  logic               v2;
  izp_pkg::izp_meta_t m2;
  logic [32:0]        w2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m2 <= m1;
    w2 <= w1;
  end

  // stage 3: weighted taps per channel
  logic               v3;
  izp_pkg::izp_meta_t m3;
  logic [40:0]        prod3 [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    m3 <= m2;
    for (int t = 0; t < 4; t++) begin
      for (int k = 0; k < 4; k++) begin
        prod3[t][k] <= 41'(pix[t][8*k +: 8]) * 41'(w2[t]);
      end
    end
  end

  // stage 4: sum, round to nearest, clamp
  logic               v4;
  izp_pkg::izp_meta_t m4;
  logic [7:0]         c4 [4];
  logic [42:0]        sum [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = 43'(prod3[0][k]) + 43'(prod3[1][k]) + 43'(prod3[2][k])
             + 43'(prod3[3][k]) + 43'h0_8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    m4 <= m3;
    for (int k = 0; k < 4; k++) begin
      c4[k] <= (sum[k][42:32] > 11'd255) ? 8'd255 : sum[k][39:32];
    end
  end

  // stage 5: blend over the background grey
  logic               v5, opaque5;
  izp_pkg::izp_meta_t m5;
  logic [15:0]        x5 [3];
  logic [7:0]         c5 [3];
  logic [7:0]         inv_a;

  assign inv_a = izp_pkg::ALPHA_OPAQUE - c4[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    m5      <= m4;
    opaque5 <= (c4[3] == izp_pkg::ALPHA_OPAQUE);
    for (int k = 0; k < 3; k++) begin
      c5[k] <= c4[k];
      x5[k] <= 16'(c4[k]) * 16'(c4[3]) + 16'(izp_pkg::GREY_BACK) * 16'(inv_a);
    end
  end

  // divide by 255 as (x + x/256 + 1) / 256, exact for any x up to 65534
  logic [16:0] q255 [3];
  logic [7:0]  chan [3];
  logic [7:0]  grey;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q255[k] = ({1'b0, x5[k]} + {9'b0, x5[k][15:8]} + 17'd1) >> 8;
      chan[k] = opaque5 ? c5[k] : q255[k][7:0];
    end
  end

  assign grey = m5.grey ? izp_pkg::GREY_LIGHT : izp_pkg::GREY_DARK;

  always_comb begin
    case (m5.kind)
      izp_pkg::KIND_IMAGE: begin
        out_res = '{red: chan[0], green: chan[1], blue: chan[2], kind: m5.kind};
      end
      izp_pkg::KIND_CHECKER: begin
        out_res = '{red: grey, green: grey, blue: grey, kind: m5.kind};
      end
      default: begin
        out_res = '{red: izp_pkg::GREY_DARK, green: izp_pkg::GREY_DARK,
                    blue: izp_pkg::GREY_DARK, kind: izp_pkg::KIND_BLANK};
      end
    endcase
  end

  assign out_valid = v5 && (m5.cmd == izp_pkg::CMD_RENDER);

endmodule

FILE: hdl/image_zoom_pan_resampler.sv
// Zoom and pan resampler for an RGBA source image held on chip.
//
// Input queue: push with cmd, pixel_index, pixel_value, panel_col, panel_row;
// a word is taken when push is high and full is low. A load word writes one
// source pixel and gives no result; a render word gives one colour word.
// Result queue: red, green, blue and source_kind show the oldest result while
// empty is low; pop takes it.
// Configuration: cfg_write, cfg_index and cfg_data write one register; write
// only while no words are in flight.
//
// One word is taken per cycle while full is low. A render word passes the
// mapping pipeline, with its two 25-stage dividers (one quotient bit a
// stage), then the middle queue, then the sampling pipeline around the four
// image memory copies, which give the four bilinear taps in one read, and
// then the result queue.
// When pop is held low, results gather in an 8-deep result queue and a
// 32-deep queue between the two pipelines; full rises once those are spoken
// for, and nothing is dropped. Reset empties both queues and restores the
// register defaults; the image memory is not cleared.
module image_zoom_pan_resampler #(
  parameter int MAX_PIXELS   = 65536,
  parameter int MAX_SIDE     = 256,
  parameter int CHECKER_CELL = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [15:0] pixel_index,
  input  logic [31:0] pixel_value,
  input  logic [13:0] panel_col,
  input  logic [13:0] panel_row,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [1:0]  source_kind,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [8:0] SIDE_CAP = 9'((MAX_SIDE > 511) ? 511 : MAX_SIDE);
  localparam int MQ_CW = $clog2(izp_pkg::MIDQ_DEPTH + 1);
  localparam int OQ_CW = $clog2(izp_pkg::OUTQ_DEPTH + 1);
  localparam int IW = $bits(izp_pkg::izp_item_t);
  localparam int RW = $bits(izp_pkg::izp_result_t);

  logic [8:0]  image_width, image_height;
  logic        image_present;
  logic [23:0] zoom_factor;
  logic [15:0] pan_offset_x, pan_offset_y;
  logic [14:0] panel_width, panel_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 9'd1;
      image_height  <= 9'd1;
      image_present <= 1'b0;
      zoom_factor   <= izp_pkg::ZOOM_UNITY;
      pan_offset_x  <= '0;
      pan_offset_y  <= '0;
      panel_width   <= 15'd1024;
      panel_height  <= 15'd768;
    end else if (cfg_write) begin
      case (cfg_index)
        izp_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[8:0];
        izp_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[8:0];
        izp_pkg::REG_IMAGE_PRESENT: image_present <= cfg_data[0];
        izp_pkg::REG_ZOOM_FACTOR:   zoom_factor   <= cfg_data;
        izp_pkg::REG_PAN_OFFSET_X:  pan_offset_x  <= cfg_data[15:0];
        izp_pkg::REG_PAN_OFFSET_Y:  pan_offset_y  <= cfg_data[15:0];
        izp_pkg::REG_PANEL_WIDTH:   panel_width   <= cfg_data[14:0];
        izp_pkg::REG_PANEL_HEIGHT:  panel_height  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  izp_pkg::izp_cfg_t cfg;

  always_comb begin
    cfg.width   = (image_width > SIDE_CAP) ? SIDE_CAP : image_width;
    cfg.height  = (image_height > SIDE_CAP) ? SIDE_CAP : image_height;
    cfg.present = image_present;
    cfg.zoom    = (zoom_factor < izp_pkg::ZOOM_MIN) ? izp_pkg::ZOOM_MIN : zoom_factor;
    cfg.pan_x   = pan_offset_x;
    cfg.pan_y   = pan_offset_y;
    cfg.panel_w = panel_width;
    cfg.panel_h = panel_height;
  end

  logic               accept;
  logic               f_valid;
  izp_pkg::izp_item_t f_item;
  logic [IW-1:0]      mq_rdata;
  logic               mq_empty, mq_pop;
  logic [MQ_CW-1:0]   mq_count;
  logic [MQ_CW-1:0]   front_cnt;
  logic               b_valid;
  izp_pkg::izp_result_t b_res;
  logic [RW-1:0]      oq_rdata;
  logic [OQ_CW-1:0]   oq_count;
  logic [OQ_CW-1:0]   back_cnt;
  izp_pkg::izp_result_t res;
  logic               back_done;

  assign accept = push && !full;
  // credit: every word in the mapping pipeline owns a slot of the middle queue
  assign full = ({1'b0, front_cnt} + {1'b0, mq_count}) >= (MQ_CW + 1)'(izp_pkg::MIDQ_DEPTH);
  assign mq_pop = !mq_empty &&
                  (({1'b0, back_cnt} + {1'b0, oq_count}) < (OQ_CW + 1)'(izp_pkg::OUTQ_DEPTH));

  izp_front #(.CHECKER_CELL(CHECKER_CELL)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (accept),
    .cmd         (cmd),
    .pixel_index (pixel_index),
    .pixel_value (pixel_value),
    .panel_col   (panel_col),
    .panel_row   (panel_row),
    .out_valid   (f_valid),
    .out_item    (f_item)
  );

  izp_fifo #(.WIDTH(IW), .DEPTH(izp_pkg::MIDQ_DEPTH)) u_midq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata (f_item),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty),
    .count (mq_count)
  );

  izp_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mq_pop),
    .in_item   (izp_pkg::izp_item_t'(mq_rdata)),
    .out_valid (b_valid),
    .out_res   (b_res)
  );

  // track the sampling pipeline: every word leaves it after a fixed time
  logic [4:0] back_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_line <= '0;
    end else begin
      back_line <= {back_line[3:0], mq_pop};
    end
  end

  assign back_done = back_line[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cnt <= '0;
      back_cnt  <= '0;
    end else begin
      if (accept && !f_valid) begin
        front_cnt <= front_cnt + MQ_CW'(1);
      end else if (!accept && f_valid) begin
        front_cnt <= front_cnt - MQ_CW'(1);
      end
      if (mq_pop && !back_done) begin
        back_cnt <= back_cnt + OQ_CW'(1);
      end else if (!mq_pop && back_done) begin
        back_cnt <= back_cnt - OQ_CW'(1);
      end
    end
  end

  izp_fifo #(.WIDTH(RW), .DEPTH(izp_pkg::OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .wdata (b_res),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty),
    .count (oq_count)
  );

  assign res         = izp_pkg::izp_result_t'(oq_rdata);
  assign red         = res.red;
  assign green       = res.green;
  assign blue        = res.blue;
  assign source_kind = res.kind;

endmodule

FILE: hdl/izp_checker.sv
module izp_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [1:0] source_kind
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> source_kind != 2'd3)
    else $error("unknown source kind");

  a_blank_grey: assert property (@(posedge clk) disable iff (rst)
    (!empty && source_kind == izp_pkg::KIND_BLANK) |->
      (red == izp_pkg::GREY_DARK && green == izp_pkg::GREY_DARK &&
       blue == izp_pkg::GREY_DARK))
    else $error("blank fill is not flat grey");

  a_checker_grey: assert property (@(posedge clk) disable iff (rst)
    (!empty && source_kind == izp_pkg::KIND_CHECKER) |->
      (red == green && green == blue &&
       (red == izp_pkg::GREY_DARK || red == izp_pkg::GREY_LIGHT)))
    else $error("checkerboard colour out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(red) && $stable(source_kind)))
    else $error("waiting result changed");

endmodule

bind image_zoom_pan_resampler izp_checker u_izp_checker (.*);
